// File: sv/gcfh_pkg.sv
// shared types and constants for the grid cell first-hit counter
`timescale 1ns / 1ps
package gcfh_pkg;

	localparam int COORD_W = 16;
	localparam int REG_W   = 15;
	localparam int CNT_W   = 7;
	localparam int HITS_W  = 3;
	localparam int DIV_NW  = 24;
	localparam int DIV_DW  = 16;
	localparam int DIV_QW  = 25;
	localparam int MUL_W   = 18;
	localparam int PROD_W  = 36;

	typedef enum logic [2:0] {
		REG_GRID_MODE   = 3'd0,
		REG_BALL_RADIUS = 3'd1,
		REG_CELL_SPACE  = 3'd2,
		REG_CELLS_X     = 3'd3,
		REG_CELLS_Y     = 3'd4,
		REG_CELL_WIDTH  = 3'd5,
		REG_CELL_HEIGHT = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		DIV_H  = 3'd0,
		DIV_B0 = 3'd1,
		DIV_B1 = 3'd2,
		DIV_R0 = 3'd3,
		DIV_R1 = 3'd4
	} div_sel_t;

	typedef enum logic [3:0] {
		MUL_NONE = 4'd0,
		MUL_SS   = 4'd1,
		MUL_RR   = 4'd2,
		MUL_C2A  = 4'd3,
		MUL_C2B  = 4'd4,
		MUL_SQA  = 4'd5,
		MUL_SQB  = 4'd6,
		MUL_DA   = 4'd7,
		MUL_DB   = 4'd8,
		MUL_NI   = 4'd9,
		MUL_CS0  = 4'd10,
		MUL_CS1  = 4'd11
	} mul_op_t;

	typedef struct packed {
		logic     load_in;
		logic     clr_en;
		logic     div_start;
		div_sel_t div_sel;
		mul_op_t  mul_op;
		logic     dd_en;
		logic     eval_en;
		logic     flag_out;
		logic     wr_chk;
		logic     out_load;
		logic [1:0] cand;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic in_grid;
	} sts_t;

endpackage

// File: sv/gcfh_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module gcfh_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: sv/gcfh_div.sv
// serial signed floor divider, one quotient bit per cycle
`timescale 1ns / 1ps
module gcfh_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [gcfh_pkg::DIV_NW-1:0]  num,
	input  logic [gcfh_pkg::DIV_DW-1:0]         den,
	output logic                                done,
	output logic signed [gcfh_pkg::DIV_QW-1:0]  quot
);

	localparam int NW    = gcfh_pkg::DIV_NW;
	localparam int DW    = gcfh_pkg::DIV_DW;
	localparam int QW    = gcfh_pkg::DIV_QW;
	localparam int STEPS = NW;
	localparam int CW    = $clog2(STEPS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [NW-1:0] mag_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic signed [QW-1:0] quot_q;

	logic [DW:0]   trial;
	logic [DW:0]   trial_sub;
	logic          ge;
	logic [DW-1:0] rem_next;
	logic signed [QW-1:0] quo_neg;
	logic          last;

	assign trial     = {rem_q, mag_q[NW-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = (trial >= {1'b0, den_q});
	assign rem_next  = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
	// floor for negative dividends: one less when there is a remainder
	assign quo_neg   = -$signed({1'b0, quo_q}) - $signed(QW'(rem_q != '0));
	assign last      = (cnt_q == CW'(STEPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			rem_q <= '0;
			quo_q <= '0;
			den_q <= den;
		end else if (busy_q && !last) begin
			mag_q <= {mag_q[NW-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[NW-2:0], ge};
		end else if (busy_q) begin
			quot_q <= neg_q ? quo_neg : $signed({1'b0, quo_q});
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: sv/gcfh_dp.sv
// datapath: index division, distance checks, hit bitmap and result register
`timescale 1ns / 1ps
module gcfh_dp #(
	parameter int AXIS_MAX = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gcfh_pkg::cmd_t                       cmd,
	output gcfh_pkg::sts_t                       sts,
	input  logic                                 grid_mode,
	input  logic [gcfh_pkg::REG_W-1:0]           ball_radius,
	input  logic [gcfh_pkg::REG_W-1:0]           cell_spacing,
	input  logic [gcfh_pkg::CNT_W-1:0]           cells_x,
	input  logic [gcfh_pkg::CNT_W-1:0]           cells_y,
	input  logic [gcfh_pkg::REG_W-1:0]           cell_width,
	input  logic [gcfh_pkg::REG_W-1:0]           cell_height,
	input  logic signed [gcfh_pkg::COORD_W-1:0]  coord_first,
	input  logic signed [gcfh_pkg::COORD_W-1:0]  coord_second,
	output logic [gcfh_pkg::HITS_W-1:0]          new_hits,
	output logic                                 outside_grid
);

	localparam int IXW   = $clog2(AXIS_MAX);
	localparam int DEPTH = AXIS_MAX * AXIS_MAX;
	localparam int ADW   = $clog2(DEPTH);
	localparam int HMAX  = (AXIS_MAX - 1) / 2;
	localparam int RW    = gcfh_pkg::REG_W;
	localparam int CNW   = gcfh_pkg::CNT_W;
	localparam int MW    = gcfh_pkg::MUL_W;

	// effective register values
	logic [RW-1:0]  s_eff, side0, side1;
	logic [CNW-1:0] cnt0, cnt1;
	logic [RW:0]    two_r;

	assign s_eff = (cell_spacing == '0) ? RW'(1) : cell_spacing;
	assign side0 = (cell_width == '0) ? RW'(1) : cell_width;
	assign side1 = (cell_height == '0) ? RW'(1) : cell_height;
	assign two_r = {ball_radius, 1'b0};

	always_comb begin
		if (cells_x == '0) begin
			cnt0 = CNW'(1);
		end else if (int'(cells_x) > AXIS_MAX) begin
			cnt0 = CNW'(AXIS_MAX);
		end else begin
			cnt0 = cells_x;
		end
		if (cells_y == '0) begin
			cnt1 = CNW'(1);
		end else if (int'(cells_y) > AXIS_MAX) begin
			cnt1 = CNW'(AXIS_MAX);
		end else begin
			cnt1 = cells_y;
		end
	end

	logic signed [15:0] x0_q, x1_q;
	logic [6:0]         h_q;
	logic signed [24:0] base0_q, base1_q;
	logic signed [17:0] c2a_q, c2b_q, dd0_q, dd1_q;
	logic [29:0]        ss_q;
	logic [31:0]        rr_q, sqa_q, sqb_q;
	logic [33:0]        da_q, db_q;
	logic [21:0]        cs0_q, cs1_q;
	logic [ADW-1:0]     nidx_q;
	logic               ok_q;
	gcfh_pkg::div_sel_t divsel_q;
	logic [2:0]         hits_q;
	logic               outside_q;
	logic [2:0]         out_hits_q;
	logic               out_outside_q;
	logic [ADW-1:0]     clr_q;

	logic signed [16:0] two_x0, two_x1;
	assign two_x0 = {x0_q, 1'b0};
	assign two_x1 = {x1_q, 1'b0};

	// candidate indices and bounds
	logic [7:0]         n_val, lim0, lim1;
	logic               b0, b1;
	logic signed [25:0] i0, i1;
	logic               inside0, inside1;
	logic [IXW-1:0]     ci0, ci1;
	logic signed [8:0]  diff0, diff1;

	assign n_val = {h_q, 1'b1};
	assign lim0  = grid_mode ? {1'b0, cnt0} : n_val;
	assign lim1  = grid_mode ? {1'b0, cnt1} : n_val;
	assign b0    = !grid_mode && cmd.cand[0];
	assign b1    = !grid_mode && cmd.cand[1];
	assign i0    = {base0_q[24], base0_q} + $signed({25'd0, b0});
	assign i1    = {base1_q[24], base1_q} + $signed({25'd0, b1});
	assign inside0 = !i0[25] && (i0 < $signed({18'd0, lim0}));
	assign inside1 = !i1[25] && (i1 < $signed({18'd0, lim1}));
	assign ci0   = i0[IXW-1:0];
	assign ci1   = i1[IXW-1:0];
	assign diff0 = $signed(9'(ci0)) - $signed(9'(h_q));
	assign diff1 = $signed(9'(ci1)) - $signed(9'(h_q));

	// shared multiplier
	logic signed [MW-1:0] ma, mb;
	logic signed [gcfh_pkg::PROD_W-1:0] prod;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_op)
			gcfh_pkg::MUL_SS: begin
				ma = $signed(MW'(s_eff));
				mb = $signed(MW'(s_eff));
			end
			gcfh_pkg::MUL_RR: begin
				ma = $signed(MW'(two_r));
				mb = $signed(MW'(two_r));
			end
			gcfh_pkg::MUL_C2A: begin
				ma = $signed(MW'(s_eff));
				mb = {{9{diff0[8]}}, diff0};
			end
			gcfh_pkg::MUL_C2B: begin
				ma = $signed(MW'(s_eff));
				mb = {{9{diff1[8]}}, diff1};
			end
			gcfh_pkg::MUL_SQA: begin
				ma = c2a_q;
				mb = c2a_q;
			end
			gcfh_pkg::MUL_SQB: begin
				ma = c2b_q;
				mb = c2b_q;
			end
			gcfh_pkg::MUL_DA: begin
				ma = dd0_q;
				mb = dd0_q;
			end
			gcfh_pkg::MUL_DB: begin
				ma = dd1_q;
				mb = dd1_q;
			end
			gcfh_pkg::MUL_NI: begin
				ma = $signed(MW'(lim0));
				mb = $signed(MW'(ci1));
			end
			gcfh_pkg::MUL_CS0: begin
				ma = $signed(MW'(cnt0));
				mb = $signed(MW'(side0));
			end
			gcfh_pkg::MUL_CS1: begin
				ma = $signed(MW'(cnt1));
				mb = $signed(MW'(side1));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = ma * mb;

	// divider operand select
	logic signed [gcfh_pkg::DIV_NW-1:0] div_num;
	logic [gcfh_pkg::DIV_DW-1:0]        div_den;
	logic                               div_done;
	logic signed [gcfh_pkg::DIV_QW-1:0] quot;

	always_comb begin
		div_num = '0;
		div_den = {1'b0, s_eff};
		case (cmd.div_sel)
			gcfh_pkg::DIV_H: begin
				div_num = $signed({8'd0, two_r});
			end
			gcfh_pkg::DIV_B0: begin
				div_num = {{7{two_x0[16]}}, two_x0};
			end
			gcfh_pkg::DIV_B1: begin
				div_num = {{7{two_x1[16]}}, two_x1};
			end
			gcfh_pkg::DIV_R0: begin
				div_num = {{7{two_x0[16]}}, two_x0} + $signed({2'd0, cs0_q});
				div_den = {side0, 1'b0};
			end
			gcfh_pkg::DIV_R1: begin
				div_num = {{7{two_x1[16]}}, two_x1} + $signed({2'd0, cs1_q});
				div_den = {side1, 1'b0};
			end
			default: begin
				div_num = '0;
			end
		endcase
	end

	gcfh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// hit bitmap
	logic [ADW-1:0] idx_addr, ram_addr;
	logic           ram_we;
	logic [0:0]     ram_wdata, ram_rdata;
	logic           hit_new;

	assign idx_addr  = ADW'(ci0) + nidx_q;
	assign ram_addr  = cmd.clr_en ? clr_q : idx_addr;
	assign hit_new   = !ram_rdata[0] && (grid_mode || ok_q);
	assign ram_we    = cmd.clr_en || (cmd.wr_chk && hit_new);
	assign ram_wdata = cmd.clr_en ? 1'b0 : 1'b1;

	gcfh_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_hit_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	logic [32:0] cn_sum;
	logic [34:0] dist_sum;
	assign cn_sum   = {1'b0, sqa_q} + {1'b0, sqb_q};
	assign dist_sum = {1'b0, da_q} + {1'b0, db_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			hits_q    <= '0;
			outside_q <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load_in) begin
				hits_q    <= '0;
				outside_q <= 1'b0;
			end else begin
				if (cmd.wr_chk && hit_new) begin
					hits_q <= hits_q + 1'b1;
				end
				if (cmd.flag_out) begin
					outside_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x0_q <= coord_first;
			x1_q <= coord_second;
		end
		if (cmd.div_start) begin
			divsel_q <= cmd.div_sel;
		end
		if (div_done) begin
			case (divsel_q)
				gcfh_pkg::DIV_H: begin
					h_q <= (quot > $signed(25'(HMAX))) ? 7'(HMAX) : quot[6:0];
				end
				gcfh_pkg::DIV_B0: base0_q <= quot + $signed({18'd0, h_q});
				gcfh_pkg::DIV_B1: base1_q <= quot + $signed({18'd0, h_q});
				gcfh_pkg::DIV_R0: base0_q <= quot;
				gcfh_pkg::DIV_R1: base1_q <= quot;
				default: base1_q <= base1_q;
			endcase
		end
		case (cmd.mul_op)
			gcfh_pkg::MUL_SS:  ss_q   <= prod[29:0];
			gcfh_pkg::MUL_RR:  rr_q   <= prod[31:0];
			gcfh_pkg::MUL_C2A: c2a_q  <= prod[17:0];
			gcfh_pkg::MUL_C2B: c2b_q  <= prod[17:0];
			gcfh_pkg::MUL_SQA: sqa_q  <= prod[31:0];
			gcfh_pkg::MUL_SQB: sqb_q  <= prod[31:0];
			gcfh_pkg::MUL_DA:  da_q   <= prod[33:0];
			gcfh_pkg::MUL_DB:  db_q   <= prod[33:0];
			gcfh_pkg::MUL_NI:  nidx_q <= prod[ADW-1:0];
			gcfh_pkg::MUL_CS0: cs0_q  <= prod[21:0];
			gcfh_pkg::MUL_CS1: cs1_q  <= prod[21:0];
			default: ;
		endcase
		if (cmd.dd_en) begin
			dd0_q <= {two_x0[16], two_x0} - c2a_q;
			dd1_q <= {two_x1[16], two_x1} - c2b_q;
		end
		if (cmd.eval_en) begin
			// centre inside the ball and point within half a spacing of it
			ok_q <= (cn_sum <= {1'b0, rr_q}) && (dist_sum <= 35'(ss_q));
		end
		if (cmd.out_load) begin
			out_hits_q    <= hits_q;
			out_outside_q <= outside_q;
		end
	end

	assign sts.clr_done = (clr_q == ADW'(DEPTH - 1));
	assign sts.div_done = div_done;
	assign sts.in_grid  = inside0 && inside1;

	assign new_hits     = out_hits_q;
	assign outside_grid = out_outside_q;

endmodule

// File: sv/gcfh_ctrl.sv
// controller state machine sequencing the datapath per transaction
`timescale 1ns / 1ps
module gcfh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           grid_mode,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output gcfh_pkg::cmd_t cmd,
	input  gcfh_pkg::sts_t sts
);

	typedef enum logic [20:0] {
		S_CLEAR    = 21'h000001,
		S_IDLE     = 21'h000002,
		S_CS0      = 21'h000004,
		S_CS1      = 21'h000008,
		S_DIV_GO   = 21'h000010,
		S_DIV_WAIT = 21'h000020,
		S_MSS      = 21'h000040,
		S_MRR      = 21'h000080,
		S_CHK      = 21'h000100,
		S_C2A      = 21'h000200,
		S_C2B      = 21'h000400,
		S_DD       = 21'h000800,
		S_SQA      = 21'h001000,
		S_SQB      = 21'h002000,
		S_DA       = 21'h004000,
		S_DB       = 21'h008000,
		S_EVAL     = 21'h010000,
		S_NI       = 21'h020000,
		S_RD       = 21'h040000,
		S_WR       = 21'h080000,
		S_DONE     = 21'h100000
	} state_t;

	state_t             state_q, state_d;
	gcfh_pkg::div_sel_t dsel_q, dsel_d;
	logic [1:0]         cand_q, cand_d;
	logic               out_valid_q;
	logic               last_cand;
	state_t             next_cand_state;

	assign last_cand       = grid_mode || (cand_q == 2'd3);
	assign next_cand_state = last_cand ? S_DONE : S_CHK;

	always_comb begin
		state_d     = state_q;
		dsel_d      = dsel_q;
		cand_d      = cand_q;
		cmd         = '0;
		cmd.div_sel = dsel_q;
		cmd.mul_op  = gcfh_pkg::MUL_NONE;
		cmd.cand    = cand_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cand_d      = 2'd0;
					if (grid_mode) begin
						state_d = S_CS0;
					end else begin
						dsel_d  = gcfh_pkg::DIV_H;
						state_d = S_DIV_GO;
					end
				end
			end
			S_CS0: begin
				cmd.mul_op = gcfh_pkg::MUL_CS0;
				state_d    = S_CS1;
			end
			S_CS1: begin
				cmd.mul_op = gcfh_pkg::MUL_CS1;
				dsel_d     = gcfh_pkg::DIV_R0;
				state_d    = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					unique case (dsel_q)
						gcfh_pkg::DIV_H: begin
							dsel_d  = gcfh_pkg::DIV_B0;
							state_d = S_DIV_GO;
						end
						gcfh_pkg::DIV_B0: begin
							dsel_d  = gcfh_pkg::DIV_B1;
							state_d = S_DIV_GO;
						end
						gcfh_pkg::DIV_B1: state_d = S_MSS;
						gcfh_pkg::DIV_R0: begin
							dsel_d  = gcfh_pkg::DIV_R1;
							state_d = S_DIV_GO;
						end
						gcfh_pkg::DIV_R1: state_d = S_CHK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_MSS: begin
				cmd.mul_op = gcfh_pkg::MUL_SS;
				state_d    = S_MRR;
			end
			S_MRR: begin
				cmd.mul_op = gcfh_pkg::MUL_RR;
				state_d    = S_CHK;
			end
			S_CHK: begin
				if (!sts.in_grid) begin
					cmd.flag_out = 1'b1;
					cand_d       = cand_q + 1'b1;
					state_d      = next_cand_state;
				end else if (grid_mode) begin
					state_d = S_NI;
				end else begin
					state_d = S_C2A;
				end
			end
			S_C2A: begin
				cmd.mul_op = gcfh_pkg::MUL_C2A;
				state_d    = S_C2B;
			end
			S_C2B: begin
				cmd.mul_op = gcfh_pkg::MUL_C2B;
				state_d    = S_DD;
			end
			S_DD: begin
				cmd.dd_en = 1'b1;
				state_d   = S_SQA;
			end
			S_SQA: begin
				cmd.mul_op = gcfh_pkg::MUL_SQA;
				state_d    = S_SQB;
			end
			S_SQB: begin
				cmd.mul_op = gcfh_pkg::MUL_SQB;
				state_d    = S_DA;
			end
			S_DA: begin
				cmd.mul_op = gcfh_pkg::MUL_DA;
				state_d    = S_DB;
			end
			S_DB: begin
				cmd.mul_op = gcfh_pkg::MUL_DB;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval_en = 1'b1;
				state_d     = S_NI;
			end
			S_NI: begin
				cmd.mul_op = gcfh_pkg::MUL_NI;
				state_d    = S_RD;
			end
			S_RD: begin
				// bitmap read in flight
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr_chk = 1'b1;
				cand_d     = cand_q + 1'b1;
				state_d    = next_cand_state;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			dsel_q      <= gcfh_pkg::DIV_H;
			cand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dsel_q  <= dsel_d;
			cand_q  <= cand_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/grid_cell_first_hit_counter.sv
// three serial divisions in ball mode or two in rectangle mode, then each on-grid ball candidate
// takes its turn on one shared multiplier and the bitmap port; an off-grid candidate is only flagged
// a transaction is taken only once the last one is through; the next is taken while a result waits
// after reset a clearing pass over all AXIS_MAX*AXIS_MAX entries zeroes the hit bitmap;
// in_stall stays high until it ends, configuration writes are taken throughout
`timescale 1ns / 1ps
module grid_cell_first_hit_counter #(
	parameter int AXIS_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [gcfh_pkg::COORD_W-1:0] coord_first,
	input  logic signed [gcfh_pkg::COORD_W-1:0] coord_second,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [gcfh_pkg::HITS_W-1:0]         new_hits,
	output logic                                outside_grid,
	input  logic                                cfg_write,
	input  logic [2:0]                          cfg_index,
	input  logic [gcfh_pkg::REG_W-1:0]          cfg_data
);

	localparam int RW  = gcfh_pkg::REG_W;
	localparam int CNW = gcfh_pkg::CNT_W;

	logic           grid_mode_q;
	logic [RW-1:0]  ball_radius_q, cell_spacing_q, cell_width_q, cell_height_q;
	logic [CNW-1:0] cells_x_q, cells_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_mode_q    <= 1'b0;
			ball_radius_q  <= RW'(2048);
			cell_spacing_q <= RW'(256);
			cells_x_q      <= CNW'(8);
			cells_y_q      <= CNW'(8);
			cell_width_q   <= RW'(256);
			cell_height_q  <= RW'(256);
		end else if (cfg_write) begin
			unique case (gcfh_pkg::reg_idx_t'(cfg_index))
				gcfh_pkg::REG_GRID_MODE:   grid_mode_q    <= cfg_data[0];
				gcfh_pkg::REG_BALL_RADIUS: ball_radius_q  <= cfg_data;
				gcfh_pkg::REG_CELL_SPACE:  cell_spacing_q <= cfg_data;
				gcfh_pkg::REG_CELLS_X:     cells_x_q      <= cfg_data[CNW-1:0];
				gcfh_pkg::REG_CELLS_Y:     cells_y_q      <= cfg_data[CNW-1:0];
				gcfh_pkg::REG_CELL_WIDTH:  cell_width_q   <= cfg_data;
				gcfh_pkg::REG_CELL_HEIGHT: cell_height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	gcfh_pkg::cmd_t cmd;
	gcfh_pkg::sts_t sts;

	gcfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_mode (grid_mode_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	gcfh_dp #(
		.AXIS_MAX (AXIS_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.grid_mode    (grid_mode_q),
		.ball_radius  (ball_radius_q),
		.cell_spacing (cell_spacing_q),
		.cells_x      (cells_x_q),
		.cells_y      (cells_y_q),
		.cell_width   (cell_width_q),
		.cell_height  (cell_height_q),
		.coord_first  (coord_first),
		.coord_second (coord_second),
		.new_hits     (new_hits),
		.outside_grid (outside_grid)
	);

	// at most four candidates per transaction
	a_hits_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_hits <= 3'd4)
		else $error("new_hits above four");

	// rectangle mode looks at a single cell
	a_rect_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grid_mode_q |-> new_hits <= 3'd1)
		else $error("rectangle transaction counted more than one cell");

	// an off-grid rectangle point never marks a cell
	a_rect_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grid_mode_q && outside_grid |-> new_hits == 3'd0)
		else $error("off-grid rectangle transaction counted a hit");

	// no input is taken while a datapath command is active
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_en || cmd.div_start || cmd.wr_chk |-> in_stall)
		else $error("input accepted while busy");

endmodule
